// ===== sv/vrtp_pkg.sv =====
// Shared types and constants for the vertex rotate/translate/project block.
// No dependencies; every other file but vrtp_checker imports this package.
package vrtp_pkg;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_ROT0   = 3'd0,
		REG_ROT1   = 3'd1,
		REG_ROT2   = 3'd2,
		REG_TRANSX = 3'd3,
		REG_TRANSY = 3'd4,
		REG_TRANSZ = 3'd5,
		REG_OFFSET = 3'd6,
		REG_PLANE  = 3'd7
	} vrtp_reg_t;

	localparam int CFG_W  = 64;
	localparam int IN_W   = 48;
	localparam int OUT_W  = 256;
	localparam int RAW_W  = 46;
	localparam int NUM_W  = 61;
	localparam int DEN_W  = 29;
	localparam int QUO_W  = 34;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic signed [RAW_W-1:0] SAT_LO = -46'sd134217728;
	localparam logic signed [RAW_W-1:0] SAT_HI = 46'sd134213632;
	localparam logic signed [RAW_W-1:0] PZ_MAX = 46'sd268435455;
	localparam logic signed [36:0]      SCR_LO = -37'sd67108864;
	localparam logic signed [36:0]      SCR_HI = 37'sd67043328;

	typedef struct packed {
		logic [2:0][47:0] rot;
		logic [2:0][31:0] trans;
		logic [63:0]      offset;
		logic [15:0]      plane;
	} vrtp_cfg_t;

	// Results that need no division
	typedef struct packed {
		logic [15:0] ir_x;
		logic [15:0] ir_y;
		logic [15:0] ir_z;
		logic [27:0] fine_x;
		logic [27:0] fine_y;
		logic [27:0] fine_z;
		logic [15:0] sz;
		logic [27:0] pz;
	} vrtp_pass_t;

	// One queued vertex: finished fields plus the two division jobs
	typedef struct packed {
		vrtp_pass_t       pass;
		logic [NUM_W-1:0] num_x;
		logic [NUM_W-1:0] num_y;
		logic             neg_x;
		logic             neg_y;
		logic [DEN_W-1:0] den;
		logic             den_zero;
	} vrtp_job_t;

endpackage

// ===== sv/vrtp_front.sv =====
// Front end: rotate, translate, saturate and build the projection divide jobs.
// Depends on vrtp_pkg.
module vrtp_front import vrtp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  vrtp_cfg_t        cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [IN_W-1:0]  in_data,
	output logic             job_valid,
	input  logic             job_ready,
	output vrtp_job_t        job
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic adv;

	logic signed [15:0] vert [3];
	logic signed [31:0] prod_s1 [3][3];
	logic signed [32:0] sa_s2 [3];
	logic signed [44:0] sb_s2 [3];
	logic signed [RAW_W-1:0] raw_s3 [3];

	logic signed [27:0] fine_c [3];
	logic [15:0] ir_c [3];
	logic [27:0] adj_c [3];
	logic [15:0] sz_c;
	logic signed [RAW_W-1:0] hz_c, pzw_c;
	logic [27:0] pz_c;

	logic signed [27:0] fine_s4 [3];
	logic [15:0] ir_s4 [3];
	logic [15:0] sz_s4;
	logic [27:0] pz_s4;

	logic signed [44:0] mul_s5 [2];
	logic signed [27:0] fine_s5 [3];
	logic [15:0] ir_s5 [3];
	logic [15:0] sz_s5;
	logic [27:0] pz_s5;

	logic [43:0] mag_c [2];
	vrtp_job_t job_s6;

	assign adv      = !v_s6 || job_ready;
	assign in_ready = adv;

	assign vert[0] = in_data[15:0];
	assign vert[1] = in_data[31:16];
	assign vert[2] = in_data[47:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Saturate, truncate and pick the divisor
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (raw_s3[i] < SAT_LO)
				fine_c[i] = SAT_LO[27:0];
			else if (raw_s3[i] > SAT_HI)
				fine_c[i] = SAT_HI[27:0];
			else
				fine_c[i] = raw_s3[i][27:0];
			adj_c[i] = fine_c[i] + (fine_c[i][27] ? 28'd4095 : 28'd0);
			ir_c[i]  = adj_c[i][27:12];
		end
		if (raw_s3[2][RAW_W-1])
			sz_c = 16'd0;
		else if (|raw_s3[2][RAW_W-1:28])
			sz_c = 16'hFFFF;
		else
			sz_c = raw_s3[2][27:12];
		hz_c  = $signed({19'd0, cfg.plane, 11'd0});
		pzw_c = (raw_s3[2] > hz_c) ? raw_s3[2] : hz_c;
		pz_c  = (pzw_c > PZ_MAX) ? PZ_MAX[27:0] : pzw_c[27:0];
		for (int l = 0; l < 2; l++)
			mag_c[l] = mul_s5[l][44] ? 44'(-mul_s5[l]) : mul_s5[l][43:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++)
					prod_s1[i][j] <= $signed(cfg.rot[i][16*j +: 16]) * vert[j];
				sa_s2[i]  <= 33'(prod_s1[i][0]) + 33'(prod_s1[i][1]);
				sb_s2[i]  <= 45'(prod_s1[i][2]) + 45'($signed({cfg.trans[i], 12'd0}));
				raw_s3[i] <= RAW_W'(sa_s2[i]) + RAW_W'(sb_s2[i]);
				fine_s4[i] <= fine_c[i];
				ir_s4[i]   <= ir_c[i];
				fine_s5[i] <= fine_s4[i];
				ir_s5[i]   <= ir_s4[i];
			end
			sz_s4 <= sz_c;
			pz_s4 <= pz_c;
			for (int l = 0; l < 2; l++)
				mul_s5[l] <= fine_s4[l] * $signed({1'b0, cfg.plane});
			sz_s5 <= sz_s4;
			pz_s5 <= pz_s4;

			job_s6.pass.ir_x   <= ir_s5[0];
			job_s6.pass.ir_y   <= ir_s5[1];
			job_s6.pass.ir_z   <= ir_s5[2];
			job_s6.pass.fine_x <= fine_s5[0];
			job_s6.pass.fine_y <= fine_s5[1];
			job_s6.pass.fine_z <= fine_s5[2];
			job_s6.pass.sz     <= sz_s5;
			job_s6.pass.pz     <= pz_s5;
			// doubled numerator plus divisor gives rounding half away from zero
			job_s6.num_x    <= {mag_c[0], 17'd0} + NUM_W'(pz_s5);
			job_s6.num_y    <= {mag_c[1], 17'd0} + NUM_W'(pz_s5);
			job_s6.neg_x    <= mul_s5[0][44];
			job_s6.neg_y    <= mul_s5[1][44];
			job_s6.den      <= {pz_s5, 1'b0};
			job_s6.den_zero <= (pz_s5 == 28'd0);
		end
	end

	assign job_valid = v_s6;
	assign job       = job_s6;

endmodule

// ===== sv/vrtp_fifo.sv =====
// Short job queue between the front end and the divide back end.
// Depends on vrtp_pkg.
module vrtp_fifo import vrtp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_valid,
	output logic      wr_ready,
	input  vrtp_job_t wr_job,
	output logic      rd_valid,
	input  logic      rd_ready,
	output vrtp_job_t rd_job
);

	vrtp_job_t mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic push, pop;

	assign wr_ready = (count_q != (QPTR_W+1)'(QDEPTH));
	assign rd_valid = (count_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_job   = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= wr_job;
	end

endmodule

// ===== sv/vrtp_back.sv =====
// Back end: pipelined restoring divide for screen x and y, offset, clamp, round.
// Depends on vrtp_pkg.
module vrtp_back import vrtp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  vrtp_cfg_t        cfg,
	input  logic             job_valid,
	output logic             job_ready,
	input  vrtp_job_t        job,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OUT_W-1:0] out_data
);

	logic en;

	logic             vd_q [QUO_W];
	logic [DEN_W-1:0] rem_s [2][QUO_W];
	logic [QUO_W-1:0] quo_s [2][QUO_W];
	logic [QUO_W-1:0] nbits_s [2][QUO_W];
	logic             neg_s [2][QUO_W];
	logic [DEN_W-1:0] den_s [QUO_W];
	logic             zero_s [QUO_W];
	vrtp_pass_t       pass_s [QUO_W];

	logic [DEN_W-1:0] rin [2][QUO_W];
	logic [QUO_W-1:0] qin [2][QUO_W];
	logic [QUO_W-1:0] nin [2][QUO_W];
	logic             negin [2][QUO_W];
	logic [DEN_W-1:0] denin [QUO_W];
	logic             zeroin [QUO_W];
	vrtp_pass_t       passin [QUO_W];
	logic [DEN_W:0]   trial [2][QUO_W];
	logic             ge [2][QUO_W];

	logic             v_a_q, v_o_q;
	logic [26:0]      sf_a [2];
	vrtp_pass_t       pass_a, pass_o;
	logic [26:0]      sf_o [2];
	logic [10:0]      sr_o [2];

	logic signed [35:0] qs_c [2];
	logic signed [36:0] sum_c [2];
	logic [26:0]        sfc [2];
	logic [26:0]        mag_c [2];
	logic [11:0]        rnd_c [2];
	logic signed [11:0] srs_c [2];
	logic [10:0]        src_c [2];
	logic [QUO_W-1:0]   qf [2];

	assign en        = !v_o_q || out_ready;
	assign job_ready = en;

	always_comb begin
		for (int k = 0; k < QUO_W; k++) begin
			if (k == 0) begin
				rin[0][k]   = DEN_W'(job.num_x[NUM_W-1:QUO_W]);
				rin[1][k]   = DEN_W'(job.num_y[NUM_W-1:QUO_W]);
				nin[0][k]   = job.num_x[QUO_W-1:0];
				nin[1][k]   = job.num_y[QUO_W-1:0];
				qin[0][k]   = '0;
				qin[1][k]   = '0;
				negin[0][k] = job.neg_x;
				negin[1][k] = job.neg_y;
				denin[k]    = job.den;
				zeroin[k]   = job.den_zero;
				passin[k]   = job.pass;
			end else begin
				for (int l = 0; l < 2; l++) begin
					rin[l][k]   = rem_s[l][k-1];
					nin[l][k]   = nbits_s[l][k-1];
					qin[l][k]   = quo_s[l][k-1];
					negin[l][k] = neg_s[l][k-1];
				end
				denin[k]  = den_s[k-1];
				zeroin[k] = zero_s[k-1];
				passin[k] = pass_s[k-1];
			end
			// one quotient bit per stage, numerator consumed from the top
			for (int l = 0; l < 2; l++) begin
				trial[l][k] = {rin[l][k], nin[l][k][QUO_W-1-k]};
				ge[l][k]    = (trial[l][k] >= {1'b0, denin[k]});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QUO_W; k++)
				vd_q[k] <= 1'b0;
			v_a_q <= 1'b0;
			v_o_q <= 1'b0;
		end else if (en) begin
			vd_q[0] <= job_valid;
			for (int k = 1; k < QUO_W; k++)
				vd_q[k] <= vd_q[k-1];
			v_a_q <= vd_q[QUO_W-1];
			v_o_q <= v_a_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QUO_W; k++) begin
				for (int l = 0; l < 2; l++) begin
					rem_s[l][k]   <= ge[l][k] ? DEN_W'(trial[l][k] - {1'b0, denin[k]})
					                         : trial[l][k][DEN_W-1:0];
					quo_s[l][k]   <= {qin[l][k][QUO_W-2:0], ge[l][k]};
					nbits_s[l][k] <= nin[l][k];
					neg_s[l][k]   <= negin[l][k];
				end
				den_s[k]  <= denin[k];
				zero_s[k] <= zeroin[k];
				pass_s[k] <= passin[k];
			end
		end
	end

	// Apply sign and offset, clamp; then round to integer pixels
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			qf[l]   = zero_s[QUO_W-1] ? '0 : quo_s[l][QUO_W-1];
			qs_c[l] = neg_s[l][QUO_W-1] ? -$signed({2'b00, qf[l]}) : $signed({2'b00, qf[l]});
			sum_c[l] = 37'($signed(cfg.offset[32*l +: 32])) + 37'(qs_c[l]);
			if (sum_c[l] < SCR_LO)
				sfc[l] = SCR_LO[26:0];
			else if (sum_c[l] > SCR_HI)
				sfc[l] = SCR_HI[26:0];
			else
				sfc[l] = sum_c[l][26:0];

			mag_c[l] = sf_a[l][26] ? 27'(-sf_a[l]) : sf_a[l];
			rnd_c[l] = 12'((28'(mag_c[l]) + 28'd32768) >> 16);
			srs_c[l] = sf_a[l][26] ? -$signed(rnd_c[l]) : $signed(rnd_c[l]);
			if (srs_c[l] > 12'sd1023)
				src_c[l] = 11'd1023;
			else if (srs_c[l] < -12'sd1024)
				src_c[l] = 11'h400;
			else
				src_c[l] = srs_c[l][10:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sf_a[0] <= sfc[0];
			sf_a[1] <= sfc[1];
			pass_a  <= pass_s[QUO_W-1];
			sf_o[0] <= sf_a[0];
			sf_o[1] <= sf_a[1];
			sr_o[0] <= src_c[0];
			sr_o[1] <= src_c[1];
			pass_o  <= pass_a;
		end
	end

	assign out_valid = v_o_q;
	assign out_data  = {4'd0, pass_o.pz, sf_o[1], sf_o[0], sr_o[1], sr_o[0], pass_o.sz,
	                    pass_o.fine_z, pass_o.fine_y, pass_o.fine_x,
	                    pass_o.ir_z, pass_o.ir_y, pass_o.ir_x};

endmodule

// ===== sv/vertex_rotate_translate_project.sv =====
// Pipeline: 6 front stages, the job queue, then 36 back stages.
// Throughput: one vertex per cycle when nothing stalls; the 34-stage divide pipeline in the back end
// and the 4-deep job queue let front and back stall independently.
// Reset (arst_n low, asynchronous): all valid flags and queue pointers clear;
// rotation returns to identity, translation, screen offset and plane to zero.
// Depends on vrtp_pkg, vrtp_front, vrtp_fifo and vrtp_back.
module vertex_rotate_translate_project import vrtp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// configuration write port
	input  logic             cfg_we,
	input  logic [2:0]       cfg_idx,
	input  logic [CFG_W-1:0] cfg_data,
	// vertex words in
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,  // vert_x, vert_y, vert_z
	// projected words out
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// ir_x, ir_y, ir_z, view_x_fine, view_y_fine, view_z_fine, depth_sz,
	// screen_x, screen_y, screen_x_fine, screen_y_fine, persp_depth, 4 zero bits
	output logic [OUT_W-1:0] m_axis_tdata
);

	vrtp_cfg_t cfg_q;
	vrtp_reg_t reg_sel;

	logic      job_valid, job_ready;
	vrtp_job_t job;
	logic      q_valid, q_ready;
	vrtp_job_t q_job;

	assign reg_sel = vrtp_reg_t'(cfg_idx);

	// Register file: ignore bits above each register's width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rot[0] <= 48'd4096;
			cfg_q.rot[1] <= 48'd4096 << 16;
			cfg_q.rot[2] <= 48'd4096 << 32;
			cfg_q.trans  <= '0;
			cfg_q.offset <= '0;
			cfg_q.plane  <= '0;
		end else if (cfg_we) begin
			unique case (reg_sel)
				REG_ROT0:   cfg_q.rot[0]   <= cfg_data[47:0];
				REG_ROT1:   cfg_q.rot[1]   <= cfg_data[47:0];
				REG_ROT2:   cfg_q.rot[2]   <= cfg_data[47:0];
				REG_TRANSX: cfg_q.trans[0] <= cfg_data[31:0];
				REG_TRANSY: cfg_q.trans[1] <= cfg_data[31:0];
				REG_TRANSZ: cfg_q.trans[2] <= cfg_data[31:0];
				REG_OFFSET: cfg_q.offset   <= cfg_data;
				REG_PLANE:  cfg_q.plane    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Front: multiply-accumulate, saturate, build divide jobs
	vrtp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job)
	);

	// Queue decouples the two halves
	vrtp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (job_valid),
		.wr_ready (job_ready),
		.wr_job   (job),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_job   (q_job)
	);

	// Back: divide, offset, clamp, round, hold the output word
	vrtp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_valid (q_valid),
		.job_ready (q_ready),
		.job       (q_job),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

// ===== sv/vrtp_checker.sv =====
// Port-level checks on the output word stream of the projection block.
// Depends on vertex_rotate_translate_project (bound below).
module vrtp_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [255:0] m_axis_tdata
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output word dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[255:252] == 4'd0)
		else $error("pad bits set");

	// positive depth means view z is at least one unit, so the divisor is nonzero
	a_depth_div: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[147:132] != 16'd0 |-> m_axis_tdata[251:224] != 28'd0)
		else $error("zero divisor with positive depth");

	// rounding keeps a nonnegative fine x nonnegative
	a_round_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[196] |-> !m_axis_tdata[158])
		else $error("screen x sign mismatch");

endmodule

bind vertex_rotate_translate_project vrtp_checker u_vrtp_checker (.*);
